// File: hdl/fpdc_pkg.sv
// ----------------------------------------------------------------------------
// Fuzzy PD controller package
// Shared widths, register indexes, reset values and the types that travel
// between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package fpdc_pkg;

  localparam int DATA_W      = 20;
  localparam int WIDTH_W     = 19;
  localparam int CFG_IDX_W   = 3;
  // Holds a set index and its right neighbour for up to sixteen sets.
  localparam int SET_IDX_W   = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_POS_MAX = 2 ** (DATA_W - 1) - 1;
  localparam int OUT_NEG_MAG = 2 ** (DATA_W - 1);

  localparam logic [CFG_IDX_W-1:0] REG_E_FIRST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_E_WIDTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_D_FIRST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_D_WIDTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_O_FIRST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_O_WIDTH = 3'd5;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic [WIDTH_W-1:0]       width_t;

  localparam sample_t RST_E_FIRST = -20'sd6434;
  localparam width_t  RST_E_WIDTH = 19'd3217;
  localparam sample_t RST_D_FIRST = -20'sd3217;
  localparam width_t  RST_D_WIDTH = 19'd1608;
  localparam sample_t RST_O_FIRST = -20'sd81920;
  localparam width_t  RST_O_WIDTH = 19'd40960;

  typedef enum logic [1:0] {
    GK_ZERO,
    GK_FULL,
    GK_DIV
  } grade_kind_e;

  // Class of one membership grade. For GK_DIV the grade is
  // ONE - floor(gap * ONE / width), with gap below width.
  typedef struct packed {
    grade_kind_e kind;
    width_t      gap;
  } grade_cls_t;

  typedef struct packed {
    logic [SET_IDX_W-1:0] e_idx;
    logic [SET_IDX_W-1:0] d_idx;
    grade_cls_t           e_lo;
    grade_cls_t           e_hi;
    grade_cls_t           d_lo;
    grade_cls_t           d_hi;
  } fz_item_t;

  // Configuration as seen by the datapath; the error and rate widths are already forced nonzero.
  typedef struct packed {
    sample_t e_first;
    width_t  e_width;
    sample_t d_first;
    width_t  d_width;
    sample_t o_first;
    width_t  o_width;
  } fz_cfg_t;

endpackage

// File: hdl/fpdc_in_if.sv
// ----------------------------------------------------------------------------
// Fuzzy PD controller input channel
// Valid/ready channel carrying one error and error-rate sample per word.
// ----------------------------------------------------------------------------
interface fpdc_in_if;
  import fpdc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t angle_error;
  sample_t rate_error;

  modport source (output valid, output angle_error, output rate_error, input ready);
  modport sink   (input valid, input angle_error, input rate_error, output ready);
endinterface

// File: hdl/fpdc_out_if.sv
// ----------------------------------------------------------------------------
// Fuzzy PD controller output channel
// Valid/ready channel carrying one crisp control word.
// ----------------------------------------------------------------------------
interface fpdc_out_if;
  import fpdc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t control_output;

  modport source (output valid, output control_output, input ready);
  modport sink   (input valid, input control_output, output ready);
endinterface

// File: hdl/fuzzy_pd_controller_core.sv
// ----------------------------------------------------------------------------
// Fuzzy PD controller core
// Two-input fuzzy controller with center-of-gravity defuzzification.
// ----------------------------------------------------------------------------
// The block takes one word per clock while in_chan.ready is high, each with an
// error and an error-rate sample, both signed Q12, and returns one signed Q12
// control word for each, in order. It sustains one word per cycle while the
// output side is ready. Most of the pipeline is the bit-per-stage divider that
// forms the center-of-gravity quotient, with FRAC_BITS more stages in the
// dividers that form the grades. A front stage classifies the sets of each
// input and picks the first active set; a four-word queue lets it keep
// accepting while the output side is stalled. The six set registers are
// written through the configuration port and must only change while no word
// is in flight. An error or rate width of zero is treated as one; the output
// width is used as written.
module fuzzy_pd_controller_core #(
  parameter int NUM_SETS  = 5,
  parameter int FRAC_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fpdc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fpdc_pkg::DATA_W-1:0]    cfg_data_i,
  fpdc_in_if.sink                        in_chan,
  fpdc_out_if.source                     out_chan
);
  import fpdc_pkg::*;

  sample_t  e_first_q;
  width_t   e_width_q;
  sample_t  d_first_q;
  width_t   d_width_q;
  sample_t  o_first_q;
  width_t   o_width_q;
  fz_cfg_t  cfg;

  logic     front_valid;
  fz_item_t front_item;
  logic     front_ready;
  logic     queue_valid;
  fz_item_t queue_item;
  logic     queue_ready;

  // Register file; each register has its own index and reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_first_q <= RST_E_FIRST;
      e_width_q <= RST_E_WIDTH;
      d_first_q <= RST_D_FIRST;
      d_width_q <= RST_D_WIDTH;
      o_first_q <= RST_O_FIRST;
      o_width_q <= RST_O_WIDTH;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_E_FIRST: e_first_q <= cfg_data_i;
        REG_E_WIDTH: e_width_q <= cfg_data_i[WIDTH_W-1:0];
        REG_D_FIRST: d_first_q <= cfg_data_i;
        REG_D_WIDTH: d_width_q <= cfg_data_i[WIDTH_W-1:0];
        REG_O_FIRST: o_first_q <= cfg_data_i;
        REG_O_WIDTH: o_width_q <= cfg_data_i[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // The datapath sees error and rate widths of at least one.
  always_comb begin
    cfg.e_first = e_first_q;
    cfg.e_width = (e_width_q == '0) ? width_t'(1) : e_width_q;
    cfg.d_first = d_first_q;
    cfg.d_width = (d_width_q == '0) ? width_t'(1) : d_width_q;
    cfg.o_first = o_first_q;
    cfg.o_width = o_width_q;
  end

  fpdc_front #(
    .NUM_SETS (NUM_SETS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_chan      (in_chan),
    .item_valid_o (front_valid),
    .item_o       (front_item),
    .item_ready_i (front_ready)
  );

  fpdc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_item_i  (front_item),
    .push_ready_o (front_ready),
    .pop_valid_o  (queue_valid),
    .pop_item_o   (queue_item),
    .pop_ready_i  (queue_ready)
  );

  fpdc_back #(
    .NUM_SETS  (NUM_SETS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pop_valid_i (queue_valid),
    .pop_item_i  (queue_item),
    .pop_ready_o (queue_ready),
    .out_chan    (out_chan)
  );

endmodule

// File: hdl/fpdc_front.sv
// ----------------------------------------------------------------------------
// Fuzzy PD controller front end
// Accepts a sample, classifies every set of both inputs and picks the first
// active set and its neighbour; the result is held in one register stage.
// ----------------------------------------------------------------------------
module fpdc_front #(
  parameter int NUM_SETS = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fpdc_pkg::fz_cfg_t  cfg_i,
  fpdc_in_if.sink            in_chan,
  output logic               item_valid_o,
  output fpdc_pkg::fz_item_t item_o,
  input  logic               item_ready_i
);
  import fpdc_pkg::*;

  localparam int CW = DATA_W + $clog2(NUM_SETS) + 1;
  localparam int IW = $clog2(NUM_SETS);

  grade_cls_t     e_cls [NUM_SETS];
  grade_cls_t     d_cls [NUM_SETS];
  logic [IW-1:0]  e_sel;
  logic [IW-1:0]  d_sel;
  fz_item_t       item_d;
  fz_item_t       item_q;
  logic           valid_q;
  logic           accept;

  function automatic grade_cls_t cls_set(input sample_t u, input sample_t first,
                                         input width_t w, input int idx);
    logic [CW-1:0]        off;
    logic signed [CW-1:0] c;
    logic signed [CW:0]   diff;
    logic signed [CW:0]   ndiff;
    logic [CW-1:0]        mag;
    logic                 nonneg;
    grade_cls_t           cls;
    off    = CW'(w) * CW'(idx);
    c      = CW'(first) + $signed(off);
    diff   = (CW+1)'(u) - (CW+1)'(c);
    ndiff  = -diff;
    nonneg = !diff[CW];
    mag    = nonneg ? diff[CW-1:0] : ndiff[CW-1:0];
    cls.gap = mag[WIDTH_W-1:0];
    if (idx == 0 && !nonneg) begin
      cls.kind = GK_FULL;
    end else if (idx == NUM_SETS - 1 && nonneg) begin
      cls.kind = GK_FULL;
    end else if (mag < CW'(w)) begin
      cls.kind = GK_DIV;
    end else begin
      cls.kind = GK_ZERO;
    end
    return cls;
  endfunction

  always_comb begin
    for (int i = 0; i < NUM_SETS; i++) begin
      e_cls[i] = cls_set(in_chan.angle_error, cfg_i.e_first, cfg_i.e_width, i);
      d_cls[i] = cls_set(in_chan.rate_error, cfg_i.d_first, cfg_i.d_width, i);
    end
  end

  // First active set; scanning downward leaves the lowest one.
  always_comb begin
    e_sel = '0;
    d_sel = '0;
    for (int i = NUM_SETS - 1; i >= 0; i--) begin
      if (e_cls[i].kind != GK_ZERO) begin
        e_sel = IW'(i);
      end
      if (d_cls[i].kind != GK_ZERO) begin
        d_sel = IW'(i);
      end
    end
  end

  always_comb begin
    item_d.e_idx = SET_IDX_W'(e_sel);
    item_d.d_idx = SET_IDX_W'(d_sel);
    item_d.e_lo  = e_cls[e_sel];
    item_d.d_lo  = d_cls[d_sel];
    // A neighbour past the last set carries no weight.
    if (32'(e_sel) < NUM_SETS - 1) begin
      item_d.e_hi = e_cls[e_sel + IW'(1)];
    end else begin
      item_d.e_hi.kind = GK_ZERO;
      item_d.e_hi.gap  = '0;
    end
    if (32'(d_sel) < NUM_SETS - 1) begin
      item_d.d_hi = d_cls[d_sel + IW'(1)];
    end else begin
      item_d.d_hi.kind = GK_ZERO;
      item_d.d_hi.gap  = '0;
    end
  end

  assign in_chan.ready = !valid_q || item_ready_i;
  assign accept        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (item_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  // The sets cover the whole line, so the chosen set of each input is active.
  a_first_set_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (item_q.e_lo.kind != GK_ZERO && item_q.d_lo.kind != GK_ZERO))
    else $error("front picked an inactive first set");

endmodule

// File: hdl/fpdc_queue.sv
// ----------------------------------------------------------------------------
// Fuzzy PD controller decoupling queue
// Small register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module fpdc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  input  fpdc_pkg::fz_item_t push_item_i,
  output logic               push_ready_o,
  output logic               pop_valid_o,
  output fpdc_pkg::fz_item_t pop_item_o,
  input  logic               pop_ready_i
);
  import fpdc_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  fz_item_t      mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q;
  logic [PW-1:0] rd_q;
  logic [NW-1:0] cnt_q;
  logic          push;
  logic          pop;

  assign push_ready_o = cnt_q != NW'(QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_item_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (32'(wr_q) == QUEUE_DEPTH - 1) ? '0 : wr_q + PW'(1);
      end
      if (pop) begin
        rd_q <= (32'(rd_q) == QUEUE_DEPTH - 1) ? '0 : rd_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + NW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

endmodule

// File: hdl/fpdc_back.sv
// ----------------------------------------------------------------------------
// Fuzzy PD controller back end
// Pipelined grade dividers, rule evaluation, weighted sums and a pipelined
// center-of-gravity divider feeding the output register.
// ----------------------------------------------------------------------------
module fpdc_back #(
  parameter int NUM_SETS  = 5,
  parameter int FRAC_BITS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fpdc_pkg::fz_cfg_t  cfg_i,
  input  logic               pop_valid_i,
  input  fpdc_pkg::fz_item_t pop_item_i,
  output logic               pop_ready_o,
  fpdc_out_if.source         out_chan
);
  import fpdc_pkg::*;

  localparam int F     = FRAC_BITS;
  localparam int GW    = F + 1;
  localparam int CW    = DATA_W + $clog2(NUM_SETS) + 1;
  localparam int QW    = CW - 1;
  localparam int WTW   = 2 * F + 1;
  localparam int PW    = WTW + CW;
  localparam int NW    = PW + 2;
  localparam int DNW   = WTW + 2;
  localparam int KW    = $clog2(NUM_SETS);
  localparam int MID   = (NUM_SETS - 1) / 2;
  localparam int LANES = 4;
  localparam int RULES = 4;
  localparam int AW    = SET_IDX_W + 2;
  localparam logic [GW-1:0] ONE = {1'b1, {F{1'b0}}};

  logic en;

  // Grade division stages: stage s holds s quotient bits.
  logic         gv_q   [0:F];
  fz_item_t     gi_q   [0:F];
  width_t       grem_q [0:F][LANES];
  logic [F-1:0] gquo_q [0:F][LANES];
  width_t       grem_d [1:F][LANES];
  logic [F-1:0] gquo_d [1:F][LANES];

  // Rule stages.
  logic                   r1v_q;
  logic [GW-1:0]          s_q   [RULES];
  logic [KW-1:0]          k_q   [RULES];
  logic [GW-1:0]          s_d   [RULES];
  logic [KW-1:0]          k_d   [RULES];
  logic [GW-1:0]          grade [LANES];
  logic                   r2v_q;
  logic [WTW-1:0]         wt_q  [RULES];
  logic signed [CW-1:0]   ctr_q [RULES];
  logic                   r3v_q;
  logic signed [PW-1:0]   prod_q[RULES];
  logic [WTW-1:0]         wt3_q [RULES];
  logic                   r4v_q;
  logic signed [NW-1:0]   num_q;
  logic [DNW-1:0]         den_q;
  logic signed [NW-1:0]   num_d;
  logic [DNW-1:0]         den_d;

  // Center-of-gravity division stages.
  logic                   dv_q   [0:QW];
  logic [DNW-1:0]         drem_q [0:QW];
  logic [QW-1:0]          dlow_q [0:QW];
  logic [QW-1:0]          dquo_q [0:QW];
  logic [DNW-1:0]         dden_q [0:QW];
  logic                   dneg_q [0:QW];
  logic                   ddz_q  [0:QW];
  logic [DNW-1:0]         drem_d [1:QW];
  logic [QW-1:0]          dquo_d [1:QW];
  logic signed [NW-1:0]   nnum;
  logic [NW-1:0]          mag;

  logic                   out_valid_q;
  sample_t                out_data_q;
  sample_t                out_data_d;
  logic [QW-1:0]          qfin;

  function automatic grade_cls_t lane_of(input fz_item_t it, input int l);
    grade_cls_t c;
    case (l)
      0:       c = it.e_lo;
      1:       c = it.e_hi;
      2:       c = it.d_lo;
      default: c = it.d_hi;
    endcase
    return c;
  endfunction

  function automatic width_t lane_gap(input fz_item_t it, input int l);
    grade_cls_t c;
    c = lane_of(it, l);
    return c.gap;
  endfunction

  assign en          = !out_valid_q || out_chan.ready;
  assign pop_ready_o = en;

  // -------------------------------------------------------------- grades
  always_comb begin
    logic [WIDTH_W:0] rem2;
    logic [WIDTH_W:0] dvs;
    for (int s = 1; s <= F; s++) begin
      for (int l = 0; l < LANES; l++) begin
        dvs  = (l < 2) ? {1'b0, cfg_i.e_width} : {1'b0, cfg_i.d_width};
        rem2 = {grem_q[s-1][l], 1'b0};
        if (rem2 >= dvs) begin
          rem2         = rem2 - dvs;
          gquo_d[s][l] = {gquo_q[s-1][l][F-2:0], 1'b1};
        end else begin
          gquo_d[s][l] = {gquo_q[s-1][l][F-2:0], 1'b0};
        end
        grem_d[s][l] = rem2[WIDTH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= F; s++) begin
        gv_q[s] <= 1'b0;
      end
    end else if (en) begin
      gv_q[0] <= pop_valid_i;
      for (int s = 1; s <= F; s++) begin
        gv_q[s] <= gv_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gi_q[0] <= pop_item_i;
      for (int l = 0; l < LANES; l++) begin
        grem_q[0][l] <= lane_gap(pop_item_i, l);
        gquo_q[0][l] <= '0;
      end
      for (int s = 1; s <= F; s++) begin
        gi_q[s] <= gi_q[s-1];
        for (int l = 0; l < LANES; l++) begin
          grem_q[s][l] <= grem_d[s][l];
          gquo_q[s][l] <= gquo_d[s][l];
        end
      end
    end
  end

  // --------------------------------------------------------------- rules
  always_comb begin
    grade_cls_t     c;
    logic [AW-1:0]  ab;
    logic [AW-1:0]  kk;
    logic [GW-1:0]  ga;
    logic [GW-1:0]  gb;
    for (int l = 0; l < LANES; l++) begin
      c = lane_of(gi_q[F], l);
      case (c.kind)
        GK_FULL: grade[l] = ONE;
        GK_DIV:  grade[l] = ONE - GW'(gquo_q[F][l]);
        default: grade[l] = '0;
      endcase
    end
    for (int r = 0; r < RULES; r++) begin
      ga = grade[r / 2];
      gb = grade[2 + (r % 2)];
      s_d[r] = (ga < gb) ? ga : gb;
      ab = AW'(gi_q[F].e_idx) + AW'(gi_q[F].d_idx) + AW'(r / 2 + r % 2);
      kk = ab - AW'(MID);
      if (ab < AW'(MID)) begin
        k_d[r] = '0;
      end else if (kk > AW'(NUM_SETS - 1)) begin
        k_d[r] = KW'(NUM_SETS - 1);
      end else begin
        k_d[r] = kk[KW-1:0];
      end
    end
  end

  always_comb begin
    num_d = '0;
    den_d = '0;
    for (int r = 0; r < RULES; r++) begin
      num_d = num_d + NW'(prod_q[r]);
      den_d = den_d + DNW'(wt3_q[r]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1v_q <= 1'b0;
      r2v_q <= 1'b0;
      r3v_q <= 1'b0;
      r4v_q <= 1'b0;
    end else if (en) begin
      r1v_q <= gv_q[F];
      r2v_q <= r1v_q;
      r3v_q <= r2v_q;
      r4v_q <= r3v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < RULES; r++) begin
        s_q[r]    <= s_d[r];
        k_q[r]    <= k_d[r];
        wt_q[r]   <= WTW'(s_q[r]) * WTW'({ONE, 1'b0} - (GW+1)'(s_q[r]));
        ctr_q[r]  <= CW'(cfg_i.o_first) + $signed(CW'(cfg_i.o_width) * CW'(k_q[r]));
        prod_q[r] <= $signed({1'b0, wt_q[r]}) * ctr_q[r];
        wt3_q[r]  <= wt_q[r];
      end
      num_q <= num_d;
      den_q <= den_d;
    end
  end

  // ------------------------------------------------- center of gravity
  assign nnum = -num_q;
  assign mag  = num_q[NW-1] ? nnum : num_q;

  always_comb begin
    logic [DNW:0] rem2;
    for (int s = 1; s <= QW; s++) begin
      rem2 = {drem_q[s-1], dlow_q[s-1][QW-1]};
      if (rem2 >= {1'b0, dden_q[s-1]}) begin
        rem2      = rem2 - {1'b0, dden_q[s-1]};
        dquo_d[s] = {dquo_q[s-1][QW-2:0], 1'b1};
      end else begin
        dquo_d[s] = {dquo_q[s-1][QW-2:0], 1'b0};
      end
      drem_d[s] = rem2[DNW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= QW; s++) begin
        dv_q[s] <= 1'b0;
      end
    end else if (en) begin
      dv_q[0] <= r4v_q;
      for (int s = 1; s <= QW; s++) begin
        dv_q[s] <= dv_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // The mean lies among the centers, so the high part is below den.
      drem_q[0] <= mag[QW+DNW-1:QW];
      dlow_q[0] <= mag[QW-1:0];
      dquo_q[0] <= '0;
      dden_q[0] <= den_q;
      dneg_q[0] <= num_q[NW-1];
      ddz_q[0]  <= den_q == '0;
      for (int s = 1; s <= QW; s++) begin
        drem_q[s] <= drem_d[s];
        dlow_q[s] <= {dlow_q[s-1][QW-2:0], 1'b0};
        dquo_q[s] <= dquo_d[s];
        dden_q[s] <= dden_q[s-1];
        dneg_q[s] <= dneg_q[s-1];
        ddz_q[s]  <= ddz_q[s-1];
      end
    end
  end

  // Result is the negated quotient, saturated to the output range.
  assign qfin = dquo_q[QW];

  always_comb begin
    if (ddz_q[QW]) begin
      out_data_d = '0;
    end else if (dneg_q[QW]) begin
      out_data_d = (qfin > QW'(OUT_POS_MAX)) ? sample_t'(OUT_POS_MAX) : DATA_W'(qfin);
    end else if (qfin > QW'(OUT_NEG_MAG)) begin
      out_data_d = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      out_data_d = -DATA_W'(qfin);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_chan.valid          = out_valid_q;
  assign out_chan.control_output = out_data_q;

  // The first rule pair always fires, so the total weight is never zero.
  a_weight_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[0] |-> !ddz_q[0])
    else $error("total rule weight is zero");

  // The quotient fits QW bits only if the preloaded remainder is below den.
  a_quotient_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_q[0] && !ddz_q[0]) |-> (drem_q[0] < dden_q[0]))
    else $error("center of gravity quotient overflows");

endmodule

// File: sim/fuzzy_pd_controller_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuzzy PD controller core testbench
// Drives error and error-rate words through the core over several set
// layouts. A scoreboard predicts each control word from its own fuzzifier
// and center-of-gravity model and checks the results in order.
// ----------------------------------------------------------------------------
module fuzzy_pd_controller_core_tb;
  import fpdc_pkg::*;

  localparam int  NUM_SETS  = 5;
  localparam int  FRAC_BITS = 12;
  localparam longint UNITY  = longint'(1) << FRAC_BITS;
  localparam int  MID_SET   = (NUM_SETS - 1) / 2;
  localparam int  N_PHASES  = 6;
  localparam int  RAND_PER_PHASE = 205;
  localparam int  CALM_AFTER = 1050;

  // Predicts control words from the current set layout and holds the words
  // that are still owed by the core, oldest first.
  class ctrl_scoreboard;
    longint  e_first, e_width, d_first, d_width, o_first, o_width;
    sample_t owed_words[$];
    int      errors;

    function new();
      e_first = RST_E_FIRST; e_width = RST_E_WIDTH;
      d_first = RST_D_FIRST; d_width = RST_D_WIDTH;
      o_first = RST_O_FIRST; o_width = RST_O_WIDTH;
      errors  = 0;
    endfunction

    task report(input string what);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
      case (idx)
        REG_E_FIRST: e_first = longint'(signed'(val));
        REG_E_WIDTH: e_width = longint'(val[WIDTH_W-1:0]);
        REG_D_FIRST: d_first = longint'(signed'(val));
        REG_D_WIDTH: d_width = longint'(val[WIDTH_W-1:0]);
        REG_O_FIRST: o_first = longint'(signed'(val));
        REG_O_WIDTH: o_width = longint'(val[WIDTH_W-1:0]);
        default: ;
      endcase
    endfunction

    // Membership grade of set i for crisp value u; shoulders saturate outward.
    function longint grade_of(input longint u, input longint first, input longint w,
                              input int i);
      longint wv, c, d, q;
      wv = (w == 0) ? 1 : w;
      c  = first + i * wv;
      if (i == 0 && u < c) return UNITY;
      if (i == NUM_SETS - 1 && u >= c) return UNITY;
      d = (u >= c) ? u - c : c - u;
      q = (d << FRAC_BITS) / wv;
      return (q >= UNITY) ? 0 : UNITY - q;
    endfunction

    function sample_t control_word(input sample_t ang, input sample_t rate);
      longint ge[NUM_SETS];
      longint gd[NUM_SETS];
      int     pe, pd, a, b, k;
      longint s, wt, ctr, num, den, res;
      for (int i = 0; i < NUM_SETS; i++) begin
        ge[i] = grade_of(longint'(ang), e_first, e_width, i);
        gd[i] = grade_of(longint'(rate), d_first, d_width, i);
      end
      pe = -1;
      pd = -1;
      for (int i = 0; i < NUM_SETS; i++) begin
        if (pe < 0 && ge[i] != 0) pe = i;
        if (pd < 0 && gd[i] != 0) pd = i;
      end
      if (pe < 0) pe = 0;
      if (pd < 0) pd = 0;
      num = 0;
      den = 0;
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          a = pe + i;
          b = pd + j;
          if (a < NUM_SETS && b < NUM_SETS) begin
            k = (a - MID_SET) + (b - MID_SET) + MID_SET;
            if (k < 0) k = 0;
            else if (k > NUM_SETS - 1) k = NUM_SETS - 1;
            s   = (ge[a] < gd[b]) ? ge[a] : gd[b];
            wt  = s * (2 * UNITY - s);
            ctr = o_first + k * o_width;
            den += wt;
            num += wt * ctr;
          end
        end
      end
      if (den == 0) begin
        res = 0;
      end else begin
        res = -(num / den);
        if (res > OUT_POS_MAX) res = OUT_POS_MAX;
        else if (res < -OUT_NEG_MAG) res = -OUT_NEG_MAG;
      end
      return sample_t'(res);
    endfunction

    function void note_input(input sample_t ang, input sample_t rate);
      owed_words.push_back(control_word(ang, rate));
    endfunction

    task check_output(input sample_t got);
      sample_t want;
      if (owed_words.size() == 0) begin
        report($sformatf("control word %0d arrived with none owed", got));
      end else begin
        want = owed_words.pop_front();
        if (got !== want)
          report($sformatf("control_output got %0d, want %0d", got, want));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DATA_W-1:0]    cfg_data_i;

  fpdc_in_if  in_bus ();
  fpdc_out_if out_bus ();

  fuzzy_pd_controller_core #(
    .NUM_SETS (NUM_SETS),
    .FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_chan   (in_bus),
    .out_chan  (out_bus)
  );

  ctrl_scoreboard sb = new();

  // Idling is switched off for the last part of the run so that the core is
  // also exercised at full rate on both sides.
  bit idle_on  = 1'b1;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_req = 1'b0;
  int words_sent = 0;

  always #5 clk_i = ~clk_i;

  // Every word the core hands over is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) sb.check_output(out_bus.control_output);
  end

  // Receiver: ready toggles in random bursts; on request it holds off for a
  // long stretch so that the internal queue fills and the input stalls.
  initial begin
    out_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // Offers one word and returns once the core has taken it. Valid stays high
  // between back-to-back words so it is never lowered and raised in one step.
  task send_word(input sample_t ang, input sample_t rate);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.angle_error <= ang;
    in_bus.rate_error  <= rate;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_input(ang, rate);
    words_sent++;
    if (words_sent > CALM_AFTER) idle_on = 1'b0;
  endtask

  // Lowers valid and waits until every owed word has come back. No word can
  // be lost, so once the queue is empty the pipeline is idle as well.
  task drain;
    in_bus.valid <= 1'b0;
    while (sb.owed_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes all six set registers, one per cycle, and mirrors them.
  task write_layout(input logic [DATA_W-1:0] vals[6]);
    logic [CFG_IDX_W-1:0] idx[6];
    idx = '{REG_E_FIRST, REG_E_WIDTH, REG_D_FIRST, REG_D_WIDTH, REG_O_FIRST, REG_O_WIDTH};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.set_reg(idx[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Draws a crisp value, mostly around the sets of one input and sometimes
  // anywhere in the field.
  function sample_t pick_value(input longint first, input longint w);
    longint wv, lo, span;
    wv = (w == 0) ? 1 : w;
    if ($urandom_range(0, 4) == 0) return sample_t'($urandom);
    lo   = first - 2 * wv;
    span = (NUM_SETS + 3) * wv;
    if (span > 32'h7fff_ffff) span = 32'h7fff_ffff;
    return sample_t'(lo + longint'($urandom_range(0, int'(span))));
  endfunction

  initial begin
    logic [DATA_W-1:0] layout[6];
    sample_t edge_vals[6];

    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= REG_E_FIRST;
    cfg_data_i         <= '0;
    in_bus.valid       <= 1'b0;
    in_bus.angle_error <= '0;
    in_bus.rate_error  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at the reset layout: field extremes, set centers, the
    // points between sets, and both shoulders.
    edge_vals = '{-20'sd524288, 20'sd524287, 20'sd0, -20'sd1, -20'sd6434, 20'sd6434};
    foreach (edge_vals[i]) send_word(edge_vals[i], edge_vals[5 - i]);
    for (int i = 0; i < NUM_SETS; i++) begin
      send_word(sample_t'(-6434 + i * 3217), sample_t'(-3217 + i * 1608));
      send_word(sample_t'(-6434 + i * 3217 + 1608), sample_t'(-3217 + i * 1608 + 804));
    end
    send_word(sample_t'(-6435), sample_t'(6433));
    send_word(sample_t'(6433), sample_t'(-3218));
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: layout = '{RST_E_FIRST, DATA_W'(RST_E_WIDTH), RST_D_FIRST,
                      DATA_W'(RST_D_WIDTH), RST_O_FIRST, DATA_W'(RST_O_WIDTH)};
        // Zero widths, one of them hidden behind the unused top data bit.
        1: layout = '{20'h80000, 20'h00000, 20'h7ffff, 20'h80000, 20'h80000, 20'h00000};
        // Widest sets with the first centers at both ends of the field.
        2: layout = '{20'h7ffff, 20'h7ffff, 20'h80000, 20'h7ffff, 20'h7ffff, 20'h7ffff};
        3: layout = '{20'h00000, 20'h00001, 20'h00000, 20'h00001, 20'h00000, 20'h00001};
        default: begin
          for (int i = 0; i < 6; i += 2) begin
            layout[i]     = $urandom;
            layout[i + 1] = $urandom_range(1, 1 << ($urandom_range(0, 18)));
          end
          if ($urandom_range(0, 1) == 0) layout[5][19] = 1'b1;
        end
      endcase
      write_layout(layout);
      if (ph == 0) hold_req = 1'b1;
      for (int n = 0; n < RAND_PER_PHASE; n++)
        send_word(pick_value(sb.e_first, sb.e_width), pick_value(sb.d_first, sb.d_width));
      drain();
    end

    repeat (60) @(posedge clk_i);
    if (sb.owed_words.size() != 0)
      sb.report($sformatf("%0d control words never arrived", sb.owed_words.size()));
    if (sb.errors == 0) begin
      $display("fuzzy_pd_controller_core_tb OK");
    end else begin
      $display("fuzzy_pd_controller_core_tb NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10ms;
    $display("fuzzy_pd_controller_core_tb NOT OK");
    $finish;
  end

endmodule
